@@ rtl/stl_pkg.sv @@
// Shared types, kind codes and character classes of the source text lexer.
// Used by source_text_lexer and its bound port checker; no dependencies.
package stl_pkg;

    // Scanner mode between characters
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_HELD   = 2'd3
    } t_mode;

    // Token kind codes
    localparam logic [4:0] K_BAD      = 5'd0;
    localparam logic [4:0] K_IDENT    = 5'd1;
    localparam logic [4:0] K_NUMBER   = 5'd2;
    localparam logic [4:0] K_EQ_EQ    = 5'd3;
    localparam logic [4:0] K_NOT_EQ   = 5'd4;
    localparam logic [4:0] K_LESS_EQ  = 5'd5;
    localparam logic [4:0] K_GRTR_EQ  = 5'd6;
    localparam logic [4:0] K_LPAREN   = 5'd7;
    localparam logic [4:0] K_RPAREN   = 5'd8;
    localparam logic [4:0] K_LBRACKET = 5'd9;
    localparam logic [4:0] K_RBRACKET = 5'd10;
    localparam logic [4:0] K_LBRACE   = 5'd11;
    localparam logic [4:0] K_RBRACE   = 5'd12;
    localparam logic [4:0] K_DOLLAR   = 5'd13;
    localparam logic [4:0] K_BANG     = 5'd14;
    localparam logic [4:0] K_MINUS    = 5'd15;
    localparam logic [4:0] K_PLUS     = 5'd16;
    localparam logic [4:0] K_SLASH    = 5'd17;
    localparam logic [4:0] K_STAR     = 5'd18;
    localparam logic [4:0] K_PERCENT  = 5'd19;
    localparam logic [4:0] K_COLON    = 5'd20;
    localparam logic [4:0] K_SEMI     = 5'd21;
    localparam logic [4:0] K_DQUOTE   = 5'd22;
    localparam logic [4:0] K_SQUOTE   = 5'd23;
    localparam logic [4:0] K_DOT      = 5'd24;
    localparam logic [4:0] K_GREATER  = 5'd25;
    localparam logic [4:0] K_LESS     = 5'd26;
    localparam logic [4:0] K_END      = 5'd27;

    // Character codes
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // Result width and result queue sizing
    localparam int OUT_W       = 16;
    localparam int MAX_RESULTS = 3;
    localparam int QDEPTH      = 8;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int QROOM       = QDEPTH - MAX_RESULTS;

    // One result item
    typedef struct packed {
        logic [4:0]       kind;
        logic [OUT_W-1:0] span_start;
        logic [OUT_W-1:0] text_start;
        logic [OUT_W-1:0] token_length;
        logic             last;
    } t_token;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_pair_lead(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LESS) || (c == CH_GREATER);
    endfunction

    // Kind of a one-character token; unknown bytes are bad
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h28:      k = K_LPAREN;
            8'h29:      k = K_RPAREN;
            8'h5B:      k = K_LBRACKET;
            8'h5D:      k = K_RBRACKET;
            8'h7B:      k = K_LBRACE;
            8'h7D:      k = K_RBRACE;
            8'h24:      k = K_DOLLAR;
            CH_BANG:    k = K_BANG;
            8'h2D:      k = K_MINUS;
            8'h2B:      k = K_PLUS;
            8'h2F:      k = K_SLASH;
            8'h2A:      k = K_STAR;
            8'h25:      k = K_PERCENT;
            8'h3A:      k = K_COLON;
            8'h3B:      k = K_SEMI;
            8'h22:      k = K_DQUOTE;
            8'h27:      k = K_SQUOTE;
            8'h2E:      k = K_DOT;
            CH_GREATER: k = K_GREATER;
            CH_LESS:    k = K_LESS;
            default:    k = K_BAD;
        endcase
        return k;
    endfunction

    // Kind of a two-character operator from its lead character
    function automatic logic [4:0] pair_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_EQ:   k = K_EQ_EQ;
            CH_BANG: k = K_NOT_EQ;
            CH_LESS: k = K_LESS_EQ;
            default: k = K_GRTR_EQ;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/source_text_lexer.sv @@
// Source text lexer: one character per item in, tokens out through a result queue.
// An accepted character is held in the input register; its tokens are written to the
// queue when it has room, and the output port reads the queue head combinationally.
// Throughput: one character per cycle while the 8-entry queue has room for three
// tokens; tokens leave one per cycle, so the output port sets the long-run rate.
// Reset (synchronous, active low) empties the queue and returns the scanner to idle.
module source_text_lexer
    import stl_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] span_start, [31:16] text_start,
                                        // [47:32] token_length
    output logic [4:0]  m_axis_tuser,   // [4:0] tok_type
    output logic        m_axis_tlast    // last_token
);

    localparam int NCAND = 4;

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_eot;

    // Scanner state
    t_mode                    r_mode, n_mode;
    logic [7:0]               r_held, n_held;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_triv, n_triv;
    logic [POSITION_BITS-1:0] r_ots, n_ots;

    // Result queue
    t_token            r_queue [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // Candidate results of the current character, in emit order
    t_token       cand     [NCAND];
    logic         cand_v   [NCAND];
    logic [1:0]   cand_off [NCAND];
    logic [1:0]   n_wr;

    logic advance;
    logic out_take;

    assign advance       = r_in_valid && (r_count <= QCNT_W'(QROOM));
    assign s_axis_tready = !r_in_valid || advance;
    assign out_take      = m_axis_tvalid && m_axis_tready;

    // Input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_eot  <= s_axis_tlast;
        end
    end

    // Scanner step: close or extend the open token, start a new one, handle end of text
    always_comb begin
        logic [7:0]               c;
        logic [POSITION_BITS-1:0] p;
        logic [POSITION_BITS-1:0] nxt;
        logic                     consumed;
        logic [4:0]               ck;

        c   = r_in_char;
        p   = r_pos;
        nxt = r_pos + POSITION_BITS'(1);
        consumed = 1'b0;
        ck       = K_BAD;
        n_mode = r_mode;
        n_held = r_held;
        n_triv = r_triv;
        n_ots  = r_ots;
        for (int i = 0; i < NCAND; i++) begin
            cand[i]   = '0;
            cand_v[i] = 1'b0;
        end

        // Open token continues, completes as a pair, or closes
        if ((r_mode == MODE_IDENT) && (is_letter(c) || is_digit(c))) begin
            consumed = 1'b1;
        end else if ((r_mode == MODE_NUMBER) && is_digit(c)) begin
            consumed = 1'b1;
        end else if ((r_mode == MODE_HELD) && (c == CH_EQ)) begin
            cand_v[0] = 1'b1;
            cand[0]   = '{pair_kind(r_held), OUT_W'(r_triv), OUT_W'(r_ots),
                          OUT_W'(2), 1'b0};
            n_triv   = nxt;
            n_mode   = MODE_IDLE;
            n_held   = '0;
            consumed = 1'b1;
        end else if (r_mode != MODE_IDLE) begin
            if (r_mode == MODE_IDENT) begin
                ck = K_IDENT;
            end else if (r_mode == MODE_NUMBER) begin
                ck = K_NUMBER;
            end else begin
                ck = single_kind(r_held);
            end
            cand_v[0] = 1'b1;
            cand[0]   = '{ck, OUT_W'(r_triv), OUT_W'(r_ots), OUT_W'(p - r_ots), 1'b0};
            n_triv = p;
            n_mode = MODE_IDLE;
            n_held = '0;
        end

        // Character starts something new
        if (!consumed) begin
            if (is_space(c)) begin
                n_mode = n_mode;
            end else if (is_letter(c)) begin
                n_mode = MODE_IDENT;
                n_ots  = p;
            end else if (is_digit(c)) begin
                n_mode = MODE_NUMBER;
                n_ots  = p;
            end else if (is_pair_lead(c)) begin
                n_mode = MODE_HELD;
                n_held = c;
                n_ots  = p;
            end else begin
                cand_v[1] = 1'b1;
                cand[1]   = '{single_kind(c), OUT_W'(n_triv), OUT_W'(p), OUT_W'(1), 1'b0};
                n_triv = nxt;
            end
        end

        n_pos = nxt;

        // End of text: close what is open, emit the end token, start over
        if (r_in_eot) begin
            if (n_mode != MODE_IDLE) begin
                if (n_mode == MODE_IDENT) begin
                    ck = K_IDENT;
                end else if (n_mode == MODE_NUMBER) begin
                    ck = K_NUMBER;
                end else begin
                    ck = single_kind(n_held);
                end
                cand_v[2] = 1'b1;
                cand[2]   = '{ck, OUT_W'(n_triv), OUT_W'(n_ots),
                              OUT_W'(nxt - n_ots), 1'b0};
                n_triv = nxt;
            end
            cand_v[3] = 1'b1;
            cand[3]   = '{K_END, OUT_W'(n_triv), OUT_W'(nxt), OUT_W'(0), 1'b0};
            n_mode = MODE_IDLE;
            n_held = '0;
            n_pos  = '0;
            n_triv = '0;
            n_ots  = '0;
        end

        // Mark the final result of this item
        if (cand_v[3]) begin
            cand[3].last = 1'b1;
        end else if (cand_v[1]) begin
            cand[1].last = 1'b1;
        end else begin
            cand[0].last = 1'b1;
        end
    end

    // Queue slot offsets of the candidates and write count
    always_comb begin
        cand_off[0] = 2'd0;
        cand_off[1] = cand_off[0] + 2'(cand_v[0]);
        cand_off[2] = cand_off[1] + 2'(cand_v[1]);
        cand_off[3] = cand_off[2] + 2'(cand_v[2]);
        n_wr        = cand_off[3] + 2'(cand_v[3]);
    end

    // Scanner state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_held <= '0;
            r_pos  <= '0;
            r_triv <= '0;
            r_ots  <= '0;
        end else if (advance) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_pos  <= n_pos;
            r_triv <= n_triv;
            r_ots  <= n_ots;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < NCAND; i++) begin
                if (cand_v[i]) begin
                    r_queue[r_wr_ptr + QPTR_W'(cand_off[i])] <= cand[i];
                end
            end
        end
    end

    // Result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (advance) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(n_wr);
            end
            if (out_take) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (advance ? QCNT_W'(n_wr) : '0) - QCNT_W'(out_take);
        end
    end

    // Output port
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tuser  = r_queue[r_rd_ptr].kind;
    assign m_axis_tlast  = r_queue[r_rd_ptr].last;
    assign m_axis_tdata  = {r_queue[r_rd_ptr].token_length,
                            r_queue[r_rd_ptr].text_start,
                            r_queue[r_rd_ptr].span_start};

endmodule

@@ rtl/stl_checker.sv @@
// Port checker for source_text_lexer, attached by the bind at the end of this file.
// Depends on stl_pkg for the token kind codes.
module stl_checker
    import stl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Reset leaves nothing to deliver
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // End token closes the item and has no text
    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == K_END))
            |-> (m_axis_tlast && (m_axis_tdata[47:32] == 16'd0)))
        else $error("end token without last flag or with nonzero length");

    // Two-character operators are two characters long
    a_pair_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((m_axis_tuser == K_EQ_EQ) || (m_axis_tuser == K_NOT_EQ) ||
                           (m_axis_tuser == K_LESS_EQ) || (m_axis_tuser == K_GRTR_EQ)))
            |-> (m_axis_tdata[47:32] == 16'd2))
        else $error("two-character operator with wrong length");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind source_text_lexer stl_checker u_stl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
